[hw/rtl/llkvc_pkg.sv]
// Shared types and constants for the key-value cache core.
package llkvc_pkg;

   localparam int KeyW   = 64;
   localparam int ValW   = 32;
   localparam int CntW   = 32;
   localparam int ModeW  = 2;
   localparam int CapW   = 6;
   localparam int ReqW   = 104;
   localparam int RspW   = 104;

   localparam logic [ModeW-1:0] ModeOff = 2'd0;
   localparam logic [ModeW-1:0] ModeLru = 2'd1;
   localparam logic [ModeW-1:0] ModeLfu = 2'd2;

   localparam logic CsrPolicy   = 1'b0;
   localparam logic CsrCapacity = 1'b1;

   localparam logic CmdLookup = 1'b0;
   localparam logic CmdInsert = 1'b1;

   // One queued item, passed from front end to back end.
   typedef struct packed {
      logic            command;
      logic [KeyW-1:0] lookup_key;
      logic [ValW-1:0] new_value;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_HOLD
   } back_state_type;

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      logic [CntW-1:0] r;
      r = (v == {CntW{1'b1}}) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

[hw/rtl/lru_lfu_key_value_cache_core.sv]
// Top level of the fully associative key-value cache with LRU/LFU replacement.
//  channel  | direction | accept when
//  req_*    | in        | req_tvalid & req_tready
//  rsp_*    | out       | rsp_tvalid & rsp_tready
//  csr_*    | in        | csr_we
// In the back end an item is searched and latched, then applied, and its result is
// held until taken; while a result waits, the next item is popped only as it is taken, and
// the store update must finish before the next item's search.
// Reset clears valid bits, occupancy and totals.
// A stalled result holds the back end; the front queue keeps 2 items.
module lru_lfu_key_value_cache_core #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[0], lookup_key[64:1], new_value[96:65], zero fill
   input  logic [llkvc_pkg::ReqW-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found[0], found_value[32:1], evicted[33], hit_total[65:34],
   // miss_total[97:66], zero fill
   output logic [llkvc_pkg::RspW-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [llkvc_pkg::CapW-1:0] csr_wdata
);
   import llkvc_pkg::*;

   logic [ModeW-1:0] mode_ff;
   logic [CapW-1:0]  cap_ff;
   logic             q_valid, q_pop, idle;
   item_type         q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeLru;
         cap_ff  <= CapW'(32);
      end else if (csr_we) begin
         case (csr_index)
            CsrPolicy:   mode_ff <= csr_wdata[ModeW-1:0];
            CsrCapacity: cap_ff  <= csr_wdata;
            default:     ;
         endcase
      end
   end

   llkvc_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_item, .q_pop
   );

   llkvc_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset,
      .policy_mode(mode_ff), .capacity_in_use(cap_ff),
      .q_valid, .q_item, .q_pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .idle
   );

   assert property (@(posedge clock) disable iff (reset)
      csr_we |-> idle)
      else $error("configuration written while busy");

endmodule

[hw/rtl/llkvc_front.sv]
// Front end: two-entry item queue between the request port and the back end.
module llkvc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [llkvc_pkg::ReqW-1:0] req_tdata,
   output logic                  q_valid,
   output llkvc_pkg::item_type   q_item,
   input  logic                  q_pop
);
   import llkvc_pkg::*;

   item_type   buf_ff [2];
   item_type   buf_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = buf_ff[rd_ff];

   always_comb begin
      buf_in.command    = req_tdata[0];
      buf_in.lookup_key = req_tdata[KeyW:1];
      buf_in.new_value  = req_tdata[KeyW+ValW:KeyW+1];
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = (q_pop && q_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= buf_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !(q_pop && q_valid)) |=> cnt_ff == 2'd2)
      else $error("full queue lost an item");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !push) |=> !q_valid)
      else $error("queue produced an item from nothing");

endmodule

[hw/rtl/llkvc_back.sv]
// Back end: associative match and victim search, then entry update and result.
module llkvc_back #(
   parameter int ENTRIES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [llkvc_pkg::ModeW-1:0] policy_mode,
   input  logic [llkvc_pkg::CapW-1:0]  capacity_in_use,
   input  logic                       q_valid,
   input  llkvc_pkg::item_type        q_item,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [llkvc_pkg::RspW-1:0] rsp_tdata,
   output logic                       idle
);
   import llkvc_pkg::*;

   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OccW = $clog2(ENTRIES + 1);
   localparam int Pad  = 1 << IdxW;
   localparam int SelW = 1 + CntW + IdxW;

   logic [KeyW-1:0] key_ff [ENTRIES];
   logic [ValW-1:0] val_ff [ENTRIES];
   logic [CntW-1:0] use_ff [ENTRIES];
   logic [IdxW-1:0] rank_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [OccW-1:0] occ_ff;
   logic [CntW-1:0] hits_ff, misses_ff;

   back_state_type state_ff, state_in;
   item_type        item_ff;
   logic            hit_ff, full_ff, ev_ok_ff, free_ok_ff;
   logic [IdxW-1:0] hit_idx_ff, vic_idx_ff, free_idx_ff;

   logic            hit_c, ev_ok_c, free_ok_c;
   logic [IdxW-1:0] hit_idx_c, vic_idx_c, free_idx_c;
   logic [OccW:0]   cap_c;
   logic            en_c;

   logic [SelW-1:0] sel_key [1:2*Pad-1];
   logic [IdxW-1:0] sel_idx [1:2*Pad-1];

   logic            rsp_found_ff, rsp_ev_ff;
   logic [ValW-1:0] rsp_val_ff;

   // Clamp capacity to 1..ENTRIES.
   always_comb begin
      cap_c = (capacity_in_use == '0) ? (OccW+1)'(1) : (OccW+1)'(capacity_in_use);
      if (cap_c > (OccW+1)'(ENTRIES)) cap_c = (OccW+1)'(ENTRIES);
   end

   assign en_c = (policy_mode == ModeLru) || (policy_mode == ModeLfu);

   // Match and free slot search over all entries.
   always_comb begin
      hit_c = 1'b0; hit_idx_c = '0; free_ok_c = 1'b0; free_idx_c = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && key_ff[i] == q_item.lookup_key && !hit_c) begin
            hit_c = 1'b1; hit_idx_c = IdxW'(i);
         end
         if (!valid_ff[i] && !free_ok_c) begin
            free_ok_c = 1'b1; free_idx_c = IdxW'(i);
         end
      end
   end

   // Victim search as a minimum tree; ranks of valid entries are distinct.
   // LRU takes the highest rank, LFU the lowest count then the lowest rank.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (policy_mode == ModeLru)
            sel_key[Pad+i] = {!valid_ff[i], {CntW{1'b0}}, ~rank_ff[i]};
         else
            sel_key[Pad+i] = {!valid_ff[i], use_ff[i], rank_ff[i]};
         sel_idx[Pad+i] = IdxW'(i);
      end
      for (int i = ENTRIES; i < Pad; i++) begin
         sel_key[Pad+i] = '1;
         sel_idx[Pad+i] = '0;
      end
      for (int n = Pad - 1; n >= 1; n--) begin
         if (sel_key[2*n+1] < sel_key[2*n]) begin
            sel_key[n] = sel_key[2*n+1];
            sel_idx[n] = sel_idx[2*n+1];
         end else begin
            sel_key[n] = sel_key[2*n];
            sel_idx[n] = sel_idx[2*n];
         end
      end
      ev_ok_c   = |valid_ff;
      vic_idx_c = sel_idx[1];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_HOLD;
         ST_HOLD:  if (rsp_tready) state_in = q_valid ? ST_APPLY : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: q_pop = q_valid;
         ST_HOLD: q_pop = rsp_tready && q_valid;
         default: q_pop = 1'b0;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_HOLD);
   assign idle       = (state_ff == ST_IDLE) && !q_valid;
   assign rsp_tdata  = {6'd0, misses_ff, hits_ff, rsp_ev_ff, rsp_val_ff, rsp_found_ff};

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Capture search results with the item.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff     <= q_item;
         hit_ff      <= hit_c;
         hit_idx_ff  <= hit_idx_c;
         vic_idx_ff  <= vic_idx_c;
         ev_ok_ff    <= ev_ok_c;
         free_idx_ff <= free_idx_c;
         free_ok_ff  <= free_ok_c;
         full_ff     <= ((OccW+1)'(occ_ff) >= cap_c);
      end
   end

   // Apply the item to the store.
   always_ff @(posedge clock) begin
      logic            do_ev, do_ins;
      logic [IdxW-1:0] slot, vr, hr;
      do_ev  = en_c && item_ff.command == CmdInsert && !hit_ff && full_ff && ev_ok_ff;
      do_ins = en_c && item_ff.command == CmdInsert && !hit_ff;
      // After an eviction the victim slot is the free slot to fill.
      slot   = do_ev ? vic_idx_ff : free_idx_ff;
      vr     = rank_ff[vic_idx_ff];
      hr     = rank_ff[hit_idx_ff];
      if (reset) begin
         valid_ff  <= '0;
         occ_ff    <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (state_ff == ST_APPLY) begin
         rsp_found_ff <= en_c && hit_ff;
         rsp_val_ff   <= (en_c && hit_ff && item_ff.command == CmdLookup) ?
                         val_ff[hit_idx_ff] : '0;
         rsp_ev_ff    <= do_ev;
         if (en_c && item_ff.command == CmdLookup) begin
            if (hit_ff) begin
               hits_ff <= sat_inc(hits_ff);
               if (policy_mode == ModeLru) begin
                  for (int i = 0; i < ENTRIES; i++)
                     if (valid_ff[i] && rank_ff[i] < hr) rank_ff[i] <= rank_ff[i] + 1'b1;
                  rank_ff[hit_idx_ff] <= '0;
               end else begin
                  use_ff[hit_idx_ff] <= sat_inc(use_ff[hit_idx_ff]);
               end
            end else begin
               misses_ff <= sat_inc(misses_ff);
            end
         end else if (en_c && hit_ff) begin
            val_ff[hit_idx_ff] <= item_ff.new_value;
         end else if (do_ins && (do_ev || free_ok_ff)) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && !(do_ev && IdxW'(i) == vic_idx_ff)) begin
                  if (do_ev && rank_ff[i] > vr) rank_ff[i] <= rank_ff[i];
                  else                          rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
            valid_ff[slot] <= 1'b1;
            key_ff[slot]   <= item_ff.lookup_key;
            val_ff[slot]   <= item_ff.new_value;
            use_ff[slot]   <= CntW'(1);
            rank_ff[slot]  <= '0;
            if (!do_ev) occ_ff <= occ_ff + 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OccW'(ENTRIES))
      else $error("occupancy above entry count");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |=> rsp_tvalid)
      else $error("applied item gave no result");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(hits_ff) && $stable(misses_ff))
      else $error("totals moved under stalled result");

endmodule
